@@ hw/rtl/pts_pkg.sv @@
// pts_pkg: shared widths, codes and controller/datapath structs for the
// periodic task scheduler; no dependencies
package pts_pkg;

    localparam int MODE_W        = 2;
    localparam int IVL_W         = 16;
    localparam int LIM_W         = 16;
    localparam int ID_W          = 4;
    localparam int RUN_W         = 16;
    localparam int KIND_W        = 2;
    localparam int TIME_W        = 32;
    localparam int MAX_IDS       = 16;
    localparam int MAX_TASKS_DEF = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_START = 2'd3
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_REPLY = 2'd0,
        KIND_FIRE  = 2'd1,
        KIND_COUNT = 2'd2,
        KIND_STOP  = 2'd3
    } t_kind;

    typedef struct packed {
        logic latch;
        logic exec;
        logic stop;
        logic advance;
        logic scan_init;
        logic scan_step;
        logic flush;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  running;
        logic  expired;
        logic  scan_done;
        logic  slot_due;
        logic  pend_valid;
        logic  out_free;
    } t_status;

endpackage

@@ hw/rtl/pts_req_if.sv @@
// pts_req_if: request channel of the periodic task scheduler
// depends on pts_pkg for field widths
interface pts_req_if;
    logic                       valid;
    logic                       ready;
    logic [pts_pkg::MODE_W-1:0] mode;
    logic [pts_pkg::IVL_W-1:0]  task_interval;
    logic [pts_pkg::LIM_W-1:0]  task_max_runs;
    logic [pts_pkg::ID_W-1:0]   query_index;

    modport source (output valid, output mode, output task_interval,
                    output task_max_runs, output query_index, input ready);
    modport sink   (input valid, input mode, input task_interval,
                    input task_max_runs, input query_index, output ready);
endinterface

@@ hw/rtl/pts_rsp_if.sv @@
// pts_rsp_if: result channel of the periodic task scheduler
// depends on pts_pkg for field widths
interface pts_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [pts_pkg::KIND_W-1:0] result_kind;
    logic [pts_pkg::ID_W-1:0]   task_id;
    logic [pts_pkg::RUN_W-1:0]  run_count;
    logic                       status;
    logic                       last_of_tick;

    modport source (output valid, output result_kind, output task_id,
                    output run_count, output status, output last_of_tick,
                    input ready);
    modport sink   (input valid, input result_kind, input task_id,
                    input run_count, input status, input last_of_tick,
                    output ready);
endinterface

@@ hw/rtl/pts_ctrl.sv @@
// pts_ctrl: sequencing state machine of the periodic task scheduler
// depends on pts_pkg; drives datapath commands from datapath status
module pts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    output pts_pkg::t_cmd    o_cmd,
    input  pts_pkg::t_status i_status
);
    import pts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.mode == MODE_TICK) begin
                    if (!i_status.running) begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_IDLE;
                    end else if (i_status.expired) begin
                        if (i_status.out_free) begin
                            o_cmd.stop    = 1'b1;
                            o_cmd.advance = 1'b1;
                            n_state       = S_IDLE;
                        end
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                end else if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = S_FLUSH;
                end else if (!(i_status.slot_due && i_status.pend_valid &&
                               !i_status.out_free)) begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_FLUSH: begin
                if (!i_status.pend_valid) begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.flush   = 1'b1;
                    o_cmd.advance = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/pts_datapath.sv @@
// pts_datapath: task tables, timers, slot scan and result register
// depends on pts_pkg; steered by pts_ctrl through t_cmd / t_status
module pts_datapath #(
    parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pts_pkg::TIME_W-1:0] i_cfg_wdata,
    input  logic [pts_pkg::MODE_W-1:0] i_mode,
    input  logic [pts_pkg::IVL_W-1:0]  i_task_interval,
    input  logic [pts_pkg::LIM_W-1:0]  i_task_max_runs,
    input  logic [pts_pkg::ID_W-1:0]   i_query_index,
    input  pts_pkg::t_cmd              i_cmd,
    output pts_pkg::t_status           o_status,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [pts_pkg::KIND_W-1:0] o_result_kind,
    output logic [pts_pkg::ID_W-1:0]   o_task_id,
    output logic [pts_pkg::RUN_W-1:0]  o_run_count,
    output logic                       o_status_bit,
    output logic                       o_last_of_tick
);
    import pts_pkg::*;

    localparam int CAP    = (MAX_TASKS < MAX_IDS) ? MAX_TASKS : MAX_IDS;
    localparam int USED_W = $clog2(CAP + 1);
    localparam int IDX_W  = (CAP > 1) ? $clog2(CAP) : 1;

    logic [TIME_W-1:0] r_run_dur;
    logic [IVL_W-1:0]  r_ivl_tab  [CAP];
    logic [LIM_W-1:0]  r_lim_tab  [CAP];
    logic [RUN_W-1:0]  r_cnt_tab  [CAP];
    logic [TIME_W-1:0] r_ftime_tab[CAP];
    logic [CAP-1:0]    r_fired;
    logic [USED_W-1:0] r_used;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_start;
    logic              r_running;

    t_mode             r_mode;
    logic [IVL_W-1:0]  r_ivl_in;
    logic [LIM_W-1:0]  r_lim_in;
    logic [ID_W-1:0]   r_q;

    logic [USED_W-1:0] r_slot;
    logic              r_pend_valid;
    logic [ID_W-1:0]   r_pend_id;
    logic [RUN_W-1:0]  r_pend_cnt;

    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [ID_W-1:0]   r_out_id;
    logic [RUN_W-1:0]  r_out_cnt;
    logic              r_out_status;
    logic              r_out_last;

    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  wr_idx;
    logic [RUN_W-1:0]  rd_cnt;
    logic [RUN_W-1:0]  new_cnt;
    logic [TIME_W-1:0] elapsed;
    logic              exhausted;
    logic              due;
    logic              full;
    logic              q_in_use;
    logic              add_wr;
    logic              fire_wr;
    logic              out_free;

    logic              out_load;
    t_kind             out_kind;
    logic [ID_W-1:0]   out_id;
    logic [RUN_W-1:0]  out_cnt;
    logic              out_status;
    logic              out_last;

    assign rd_idx    = i_cmd.exec ? r_q[IDX_W-1:0] : r_slot[IDX_W-1:0];
    assign wr_idx    = i_cmd.exec ? r_used[IDX_W-1:0] : r_slot[IDX_W-1:0];
    assign rd_cnt    = r_cnt_tab[rd_idx];
    assign new_cnt   = (rd_cnt == '1) ? rd_cnt : rd_cnt + RUN_W'(1);
    assign elapsed   = r_now - r_ftime_tab[rd_idx];
    assign exhausted = (r_lim_tab[rd_idx] != '0) && (rd_cnt >= r_lim_tab[rd_idx]);
    assign due       = !exhausted &&
                       (!r_fired[rd_idx] || (elapsed >= TIME_W'(r_ivl_tab[rd_idx])));
    assign full      = (r_used == USED_W'(CAP));
    assign q_in_use  = ({1'b0, r_q} < 5'(r_used));
    assign add_wr    = i_cmd.exec && (r_mode == MODE_ADD) && !full;
    assign fire_wr   = i_cmd.scan_step && due;
    assign out_free  = !r_out_valid || i_out_ready;

    assign o_status.mode       = r_mode;
    assign o_status.running    = r_running;
    assign o_status.expired    = (r_run_dur != '0) && ((r_now - r_start) >= r_run_dur);
    assign o_status.scan_done  = (r_slot == r_used);
    assign o_status.slot_due   = due;
    assign o_status.pend_valid = r_pend_valid;
    assign o_status.out_free   = out_free;

    always_comb begin
        out_load   = 1'b0;
        out_kind   = KIND_REPLY;
        out_id     = '0;
        out_cnt    = '0;
        out_status = 1'b0;
        out_last   = 1'b1;
        if (i_cmd.exec) begin
            out_load = 1'b1;
            case (r_mode)
                MODE_ADD: begin
                    out_status = full;
                    out_id     = full ? '0 : ID_W'(r_used);
                end
                MODE_QUERY: begin
                    out_kind   = KIND_COUNT;
                    out_id     = r_q;
                    out_cnt    = q_in_use ? rd_cnt : '0;
                    out_status = !q_in_use;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.stop) begin
            out_load = 1'b1;
            out_kind = KIND_STOP;
        end else if ((i_cmd.scan_step && due && r_pend_valid) ||
                     (i_cmd.flush && r_pend_valid)) begin
            out_load = 1'b1;
            out_kind = KIND_FIRE;
            out_id   = r_pend_id;
            out_cnt  = r_pend_cnt;
            out_last = i_cmd.flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_dur    <= '0;
            r_fired      <= '0;
            r_used       <= '0;
            r_now        <= '0;
            r_start      <= '0;
            r_running    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_run_dur <= i_cfg_wdata;
            end
            if (add_wr) begin
                r_fired[wr_idx] <= 1'b0;
                r_used          <= r_used + USED_W'(1);
            end
            if (fire_wr) begin
                r_fired[wr_idx] <= 1'b1;
            end
            if (i_cmd.advance) begin
                r_now <= r_now + TIME_W'(1);
            end
            if (i_cmd.exec && (r_mode == MODE_START)) begin
                r_start   <= r_now;
                r_running <= 1'b1;
            end
            if (i_cmd.stop) begin
                r_running <= 1'b0;
            end
            if (i_cmd.scan_init || i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end else if (fire_wr) begin
                r_pend_valid <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode   <= t_mode'(i_mode);
            r_ivl_in <= i_task_interval;
            r_lim_in <= i_task_max_runs;
            r_q      <= i_query_index;
        end
        if (add_wr) begin
            r_ivl_tab[wr_idx] <= r_ivl_in;
            r_lim_tab[wr_idx] <= r_lim_in;
            r_cnt_tab[wr_idx] <= '0;
        end
        if (fire_wr) begin
            r_cnt_tab[wr_idx]   <= new_cnt;
            r_ftime_tab[wr_idx] <= r_now;
            r_pend_id           <= ID_W'(r_slot);
            r_pend_cnt          <= new_cnt;
        end
        if (i_cmd.scan_init) begin
            r_slot <= '0;
        end else if (i_cmd.scan_step) begin
            r_slot <= r_slot + USED_W'(1);
        end
        if (out_load) begin
            r_out_kind   <= out_kind;
            r_out_id     <= out_id;
            r_out_cnt    <= out_cnt;
            r_out_status <= out_status;
            r_out_last   <= out_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_task_id      = r_out_id;
    assign o_run_count    = r_out_cnt;
    assign o_status_bit   = r_out_status;
    assign o_last_of_tick = r_out_last;

endmodule

@@ hw/rtl/periodic_task_scheduler_core.sv @@
// periodic_task_scheduler_core: top level, state machine plus datapath
// add, query and start: the request is latched, then executed in the decode state once the output is free, which
// registers the result; tick: the request is latched and decoded, the n tasks in use are scanned one slot a cycle
// unless a fired result waits on a stalled output, and the last fired result is then flushed into the output register
// synchronous reset clears time, run duration, run state, fill count, fired flags and output valid
module periodic_task_scheduler_core #(
    parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pts_pkg::TIME_W-1:0] i_cfg_wdata,
    pts_req_if.sink                    i_req,
    pts_rsp_if.source                  o_rsp
);
    import pts_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    req_ready;

    assign i_req.ready = req_ready;

    pts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    pts_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_mode          (i_req.mode),
        .i_task_interval (i_req.task_interval),
        .i_task_max_runs (i_req.task_max_runs),
        .i_query_index   (i_req.query_index),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_result_kind   (o_rsp.result_kind),
        .o_task_id       (o_rsp.task_id),
        .o_run_count     (o_rsp.run_count),
        .o_status_bit    (o_rsp.status),
        .o_last_of_tick  (o_rsp.last_of_tick)
    );

endmodule

@@ hw/rtl/pts_checker.sv @@
// pts_checker: port-level assertions for periodic_task_scheduler_core
// depends on pts_pkg; attached to the top level by the bind below
module pts_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_req_valid,
    input logic                       i_req_ready,
    input logic                       i_rsp_valid,
    input logic                       i_rsp_ready,
    input logic [pts_pkg::KIND_W-1:0] i_kind,
    input logic [pts_pkg::ID_W-1:0]   i_id,
    input logic [pts_pkg::RUN_W-1:0]  i_count,
    input logic                       i_status,
    input logic                       i_last
);
    import pts_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result dropped while stalled");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            $stable(i_kind) && $stable(i_id) && $stable(i_count) &&
            $stable(i_status) && $stable(i_last))
        else $error("result payload changed while stalled");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while previous one still in work");

    a_status_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status |->
            (i_kind == KIND_REPLY) || (i_kind == KIND_COUNT))
        else $error("error status on a fire or stop result");

    a_fire_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_kind == KIND_FIRE) |-> (i_count != '0))
        else $error("fire result with zero run count");

endmodule

bind periodic_task_scheduler_core pts_checker u_pts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_kind      (o_rsp.result_kind),
    .i_id        (o_rsp.task_id),
    .i_count     (o_rsp.run_count),
    .i_status    (o_rsp.status),
    .i_last      (o_rsp.last_of_tick)
);

@@ sim/tb.sv @@
// tb: self-checking testbench for periodic_task_scheduler_core
// drives requests and the run duration register, predicts every result and compares it
// depends on pts_pkg, pts_req_if, pts_rsp_if and the core
`timescale 1ns / 1ps

module tb;
    import pts_pkg::*;

    localparam int TABLE_CAP   = (MAX_TASKS_DEF < MAX_IDS) ? MAX_TASKS_DEF : MAX_IDS;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int SETTLE      = 40;
    localparam int BURST_TICKS = 40;
    localparam int PHASE_ITEMS = 50;

    typedef struct packed {
        t_mode             mode;
        logic [IVL_W-1:0]  ivl;
        logic [LIM_W-1:0]  lim;
        logic [ID_W-1:0]   qidx;
    } t_sched_req;

    typedef struct packed {
        t_kind             kind;
        logic [ID_W-1:0]   id;
        logic [RUN_W-1:0]  count;
        logic              status;
        logic              last;
    } t_sched_rsp;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               cfg_we;
    logic [TIME_W-1:0]  cfg_wdata;

    pts_req_if req_bus ();
    pts_rsp_if rsp_bus ();

    periodic_task_scheduler_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_bus),
        .o_rsp       (rsp_bus)
    );

    always #2 i_clk = ~i_clk;

    // scheduler state as predicted
    logic [IVL_W-1:0]   sched_ivl     [TABLE_CAP];
    logic [LIM_W-1:0]   sched_lim     [TABLE_CAP];
    logic [RUN_W-1:0]   sched_cnt     [TABLE_CAP];
    logic [TIME_W-1:0]  sched_fire_at [TABLE_CAP];
    logic               sched_fired   [TABLE_CAP];
    int                 sched_used = 0;
    logic [TIME_W-1:0]  sched_now = '0;
    logic [TIME_W-1:0]  sched_start = '0;
    logic               sched_running = 1'b0;
    logic [TIME_W-1:0]  sched_duration = '0;

    t_sched_req  pending_reqs [$];
    t_sched_rsp  awaited_results [$];
    logic        req_taken = 1'b0;
    logic        idle_on = 1'b1;
    int          req_gap = 0;
    int          rsp_gap = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    task automatic expect_result(input t_kind k, input logic [ID_W-1:0] id,
                                 input logic [RUN_W-1:0] cnt, input logic st,
                                 input logic last);
        t_sched_rsp e;
        e.kind   = k;
        e.id     = id;
        e.count  = cnt;
        e.status = st;
        e.last   = last;
        awaited_results.push_back(e);
    endtask

    task automatic predict_schedule(input t_sched_req r);
        logic [TIME_W-1:0] elapsed;
        t_sched_rsp        held;
        logic              have_held;
        int                slot;
        held = '0;
        have_held = 1'b0;
        case (r.mode)
            MODE_TICK: begin
                if (sched_running) begin
                    elapsed = sched_now - sched_start;
                    if (sched_duration != '0 && elapsed >= sched_duration) begin
                        sched_running = 1'b0;
                        expect_result(KIND_STOP, '0, '0, 1'b0, 1'b1);
                    end else begin
                        for (int i = 0; i < sched_used; i++) begin
                            if (sched_lim[i] != '0 && sched_cnt[i] >= sched_lim[i]) continue;
                            if (!sched_fired[i] ||
                                (sched_now - sched_fire_at[i]) >= 32'(sched_ivl[i])) begin
                                if (sched_cnt[i] != 16'hFFFF) sched_cnt[i] = sched_cnt[i] + 1'b1;
                                sched_fire_at[i] = sched_now;
                                sched_fired[i] = 1'b1;
                                if (have_held)
                                    expect_result(held.kind, held.id, held.count, 1'b0, 1'b0);
                                held.kind  = KIND_FIRE;
                                held.id    = 4'(i);
                                held.count = sched_cnt[i];
                                have_held  = 1'b1;
                            end
                        end
                        if (have_held)
                            expect_result(held.kind, held.id, held.count, 1'b0, 1'b1);
                    end
                end
                sched_now = sched_now + 1'b1;
            end
            MODE_ADD: begin
                if (sched_used >= TABLE_CAP) begin
                    expect_result(KIND_REPLY, '0, '0, 1'b1, 1'b1);
                end else begin
                    slot = sched_used;
                    sched_ivl[slot]     = r.ivl;
                    sched_lim[slot]     = r.lim;
                    sched_cnt[slot]     = '0;
                    sched_fire_at[slot] = '0;
                    sched_fired[slot]   = 1'b0;
                    sched_used++;
                    expect_result(KIND_REPLY, 4'(slot), '0, 1'b0, 1'b1);
                end
            end
            MODE_QUERY: begin
                if (int'(r.qidx) < sched_used)
                    expect_result(KIND_COUNT, r.qidx, sched_cnt[r.qidx], 1'b0, 1'b1);
                else
                    expect_result(KIND_COUNT, r.qidx, '0, 1'b1, 1'b1);
            end
            default: begin
                sched_start = sched_now;
                sched_running = 1'b1;
                expect_result(KIND_REPLY, '0, '0, 1'b0, 1'b1);
            end
        endcase
    endtask

    task automatic queue_req(input t_mode m, input logic [IVL_W-1:0] ivl,
                             input logic [LIM_W-1:0] lim, input logic [ID_W-1:0] q);
        t_sched_req r;
        r.mode = m;
        r.ivl  = ivl;
        r.lim  = lim;
        r.qidx = q;
        pending_reqs.push_back(r);
    endtask

    function automatic t_sched_req random_req();
        t_sched_req r;
        int         pick;
        pick   = $urandom_range(0, 99);
        r.ivl  = 16'($urandom);
        r.lim  = 16'($urandom);
        r.qidx = 4'($urandom);
        if (pick < 55) begin
            r.mode = MODE_TICK;
        end else if (pick < 67) begin
            r.mode = MODE_START;
        end else if (pick < 82) begin
            r.mode = MODE_ADD;
            if ($urandom_range(0, 3) != 0) begin
                r.ivl = 16'($urandom_range(0, 6));
                r.lim = 16'($urandom_range(0, 8));
            end
        end else begin
            r.mode = MODE_QUERY;
        end
        return r;
    endfunction

    task automatic wait_idle();
        while (!(pending_reqs.size() == 0 && !req_bus.valid && awaited_results.size() == 0))
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_duration(input logic [TIME_W-1:0] v);
        wait_idle();
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge i_clk);
        cfg_we    = 1'b0;
        @(posedge i_clk);
    endtask

    // driver: requests and result ready, both with random idle bursts while idle_on is set
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            rsp_bus.ready <= 1'b0;
        end else begin
            if (!(req_bus.valid && !req_taken)) begin
                req_taken = 1'b0;
                if (req_gap > 0) begin
                    req_gap--;
                    req_bus.valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    if (idle_on && $urandom_range(0, 9) == 0) begin
                        req_gap = $urandom_range(1, 15) - 1;
                        req_bus.valid <= 1'b0;
                    end else begin
                        req_bus.valid         <= 1'b1;
                        req_bus.mode          <= pending_reqs[0].mode;
                        req_bus.task_interval <= pending_reqs[0].ivl;
                        req_bus.task_max_runs <= pending_reqs[0].lim;
                        req_bus.query_index   <= pending_reqs[0].qidx;
                    end
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
            if (rsp_gap > 0) begin
                rsp_gap--;
                rsp_bus.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                rsp_gap = $urandom_range(1, 15) - 1;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // monitor: register writes, accepted requests and accepted results
    always @(posedge i_clk) begin
        t_sched_rsp e;
        if (i_rst_n) begin
            if (cfg_we) sched_duration = cfg_wdata;
            if (req_bus.valid && req_bus.ready) begin
                predict_schedule(pending_reqs[0]);
                void'(pending_reqs.pop_front());
                req_taken = 1'b1;
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (awaited_results.size() == 0) begin
                    if (mismatch_count < 100)
                        $display("%0t: unexpected result kind=%0d id=%0d count=%0d",
                                 $time, rsp_bus.result_kind, rsp_bus.task_id,
                                 rsp_bus.run_count, " status=%0d last=%0d",
                                 rsp_bus.status, rsp_bus.last_of_tick);
                    mismatch_count++;
                end else begin
                    e = awaited_results.pop_front();
                    if (rsp_bus.result_kind !== e.kind || rsp_bus.task_id !== e.id ||
                        rsp_bus.run_count !== e.count || rsp_bus.status !== e.status ||
                        rsp_bus.last_of_tick !== e.last) begin
                        if (mismatch_count < 100)
                            $display("%0t: mismatch expected kind=%0d id=%0d count=%0d",
                                     $time, e.kind, e.id, e.count,
                                     " status=%0d last=%0d", e.status, e.last,
                                     " actual kind=%0d id=%0d count=%0d",
                                     rsp_bus.result_kind, rsp_bus.task_id, rsp_bus.run_count,
                                     " status=%0d last=%0d",
                                     rsp_bus.status, rsp_bus.last_of_tick);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("periodic_task_scheduler_core verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        req_bus.valid         = 1'b0;
        req_bus.mode          = '0;
        req_bus.task_interval = '0;
        req_bus.task_max_runs = '0;
        req_bus.query_index   = '0;
        rsp_bus.ready         = 1'b0;
        for (int i = 0; i < TABLE_CAP; i++) begin
            sched_ivl[i] = '0;
            sched_lim[i] = '0;
            sched_cnt[i] = '0;
            sched_fire_at[i] = '0;
            sched_fired[i] = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, tick while stopped, one every-tick task
        queue_req(MODE_QUERY, 16'h0000, 16'h0000, 4'd0);
        queue_req(MODE_QUERY, 16'hFFFF, 16'hFFFF, 4'd15);
        queue_req(MODE_TICK, 16'hFFFF, 16'hFFFF, 4'd15);
        queue_req(MODE_ADD, 16'd0, 16'd0, 4'd0);
        queue_req(MODE_START, 16'd0, 16'd0, 4'd0);
        repeat (3) queue_req(MODE_TICK, 16'd0, 16'd0, 4'd0);
        wait_idle();

        // back-to-back ticks on slot 0, no idling
        idle_on = 1'b0;
        @(posedge i_clk);
        repeat (BURST_TICKS) queue_req(MODE_TICK, 16'($urandom), 16'($urandom), 4'($urandom));
        queue_req(MODE_QUERY, 16'd0, 16'd0, 4'd0);
        wait_idle();
        idle_on = 1'b1;

        // one-tick run: fire then stop, then tick while stopped; extreme task fields
        write_duration(32'd1);
        queue_req(MODE_START, 16'd0, 16'd0, 4'd0);
        repeat (3) queue_req(MODE_TICK, 16'd0, 16'd0, 4'd0);
        queue_req(MODE_ADD, 16'hFFFF, 16'hFFFF, 4'd0);
        queue_req(MODE_ADD, 16'd1, 16'd1, 4'd0);
        queue_req(MODE_ADD, 16'd2, 16'd3, 4'd0);
        queue_req(MODE_ADD, 16'd0, 16'd1, 4'd0);
        queue_req(MODE_START, 16'd0, 16'd0, 4'd0);
        queue_req(MODE_TICK, 16'd0, 16'd0, 4'd0);
        queue_req(MODE_QUERY, 16'd0, 16'd0, 4'd2);
        queue_req(MODE_QUERY, 16'd0, 16'd0, 4'd4);

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: write_duration(32'hFFFF_FFFF);
                1: write_duration(32'd0);
                2: write_duration(32'd3);
                3: write_duration(32'd1);
                4: write_duration(32'($urandom_range(4, 30)));
                5: write_duration(32'd0);
                default: write_duration(32'd8);
            endcase
            if (ph == 6) idle_on = 1'b0;
            queue_req(MODE_START, 16'($urandom), 16'($urandom), 4'($urandom));
            repeat (PHASE_ITEMS) pending_reqs.push_back(random_req());
        end

        wait_idle();
        if (awaited_results.size() != 0) mismatch_count++;
        if (mismatch_count == 0)
            $display("periodic_task_scheduler_core verification clean");
        else
            $display("periodic_task_scheduler_core verification failed");
        $finish;
    end

endmodule
